@@ src/lso_pkg.sv @@
// Package: shared widths, constants, pipeline types and helpers of the LED sweep overlay.
`timescale 1ns / 1ps
package lso_pkg;

  // Field widths fixed by the pixel format and the register map
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned POS_W16 = 16;
  localparam int unsigned INT_W   = 12;
  localparam int unsigned COL_W   = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Weight arithmetic
  localparam int unsigned NUM_W  = INT_W + POS_W16;   // intensity * (width - d)
  localparam int unsigned QUOT_W = INT_W;             // quotient never exceeds intensity
  localparam int unsigned WGT_W  = 9;                 // Q1.8 weight, 256 means 1.0
  localparam int unsigned OVL_W  = CH_W + WGT_W;
  localparam logic [WGT_W-1:0] WeightOne = 9'd256;
  localparam logic [CH_W-1:0]  ChanMax   = 8'hFF;

  // Divider: restoring, a few quotient bits per register stage
  localparam int unsigned DivBitsPerStage = 3;
  localparam int unsigned DivStages       = QUOT_W / DivBitsPerStage;

  // Parameter defaults
  localparam int unsigned MaxLeds     = 4096;
  localparam int unsigned PosFracBits = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    RegCenter    = 2'd0,
    RegWidth     = 2'd1,
    RegColor     = 2'd2,
    RegIntensity = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } pix_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    pix_t             pix;
  } req_t;

  typedef struct packed {
    logic               en;
    logic [POS_W16-1:0] diff;
    pix_t               pix;
  } geo_t;

  typedef struct packed {
    logic             en;
    logic [NUM_W-1:0] num;
    pix_t             pix;
  } prod_t;

  typedef struct packed {
    logic               en;
    logic [POS_W16-1:0] rem;
    logic [QUOT_W-1:0]  bits;
    logic [QUOT_W-1:0]  quot;
    pix_t               pix;
  } div_t;

  typedef struct packed {
    logic [2:0][OVL_W-1:0] ovl;   // [2] red, [1] green, [0] blue
    pix_t                  pix;
  } mix_t;

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                               input logic [CH_W:0]   b);
    logic [CH_W+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > {2'b00, ChanMax}) ? ChanMax : s[CH_W-1:0];
  endfunction

endpackage

@@ src/lso_if.sv @@
// Interfaces: pixel request channels into and out of the sweep overlay.
`timescale 1ns / 1ps
interface lso_pix_in_if;
  logic                     valid;
  logic                     ready;
  logic [lso_pkg::IDX_W-1:0] pixel_index;
  logic [lso_pkg::CH_W-1:0]  in_red;
  logic [lso_pkg::CH_W-1:0]  in_green;
  logic [lso_pkg::CH_W-1:0]  in_blue;
  logic                     last_pixel;

  modport source (output valid, pixel_index, in_red, in_green, in_blue, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, in_red, in_green, in_blue, last_pixel,
                  output ready);
endinterface

interface lso_pix_out_if;
  logic                    valid;
  logic                    ready;
  logic [lso_pkg::CH_W-1:0] out_red;
  logic [lso_pkg::CH_W-1:0] out_green;
  logic [lso_pkg::CH_W-1:0] out_blue;
  logic                    last_out;

  modport source (output valid, out_red, out_green, out_blue, last_out, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_out, output ready);
endinterface

@@ src/lso_geom.sv @@
// Geometry stages: distance to the sweep center, enable, and weight numerator product.
`timescale 1ns / 1ps
module lso_geom #(
  parameter int unsigned MAX_LEDS      = lso_pkg::MaxLeds,
  parameter int unsigned POS_FRAC_BITS = lso_pkg::PosFracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  lso_pkg::req_t               req_i,
  input  logic [lso_pkg::POS_W16-1:0] center_i,
  input  logic [lso_pkg::POS_W16-1:0] width_i,
  input  logic [lso_pkg::INT_W-1:0]   intens_i,
  output logic                        vld_o,
  output lso_pkg::prod_t              prod_o
);
  import lso_pkg::*;

  localparam int unsigned POS_W = IDX_W + POS_FRAC_BITS;
  localparam int unsigned DW    = (POS_W > POS_W16) ? POS_W : POS_W16;

  logic [POS_W-1:0] pos;
  logic [DW-1:0]    pos_x, ctr_x, delta;
  logic             idx_ok, in_rng, en;
  geo_t             geo_d, geo_q;
  prod_t            prod_d, prod_q;
  logic             geo_vld_q, prod_vld_q;

  always_comb begin
    pos    = POS_W'(req_i.idx) << POS_FRAC_BITS;
    pos_x  = DW'(pos);
    ctr_x  = DW'(center_i);
    delta  = (pos_x >= ctr_x) ? (pos_x - ctr_x) : (ctr_x - pos_x);
    in_rng = delta <= DW'(width_i);
    idx_ok = {{(32-IDX_W){1'b0}}, req_i.idx} < 32'(MAX_LEDS);
    en     = (width_i != '0) && (intens_i != '0) && idx_ok && in_rng;
    geo_d.en   = en;
    geo_d.diff = en ? (width_i - delta[POS_W16-1:0]) : '0;
    geo_d.pix  = req_i.pix;
  end

  always_comb begin
    prod_d.en  = geo_q.en;
    prod_d.num = NUM_W'(intens_i) * NUM_W'(geo_q.diff);
    prod_d.pix = geo_q.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else if (adv_i) begin
      geo_vld_q  <= vld_i;
      prod_vld_q <= geo_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      geo_q  <= geo_d;
      prod_q <= prod_d;
    end
  end

  assign vld_o  = prod_vld_q;
  assign prod_o = prod_q;

endmodule

@@ src/lso_div.sv @@
// Pipelined restoring divider: weight quotient numerator / sweep width.
`timescale 1ns / 1ps
module lso_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  lso_pkg::prod_t              prod_i,
  input  logic [lso_pkg::POS_W16-1:0] divisor_i,
  output logic                        vld_o,
  output lso_pkg::div_t               div_o
);
  import lso_pkg::*;

  div_t                 first;
  div_t                 stg_d [DivStages];
  div_t                 stg_q [DivStages];
  logic [DivStages-1:0] vld_q;

  // Numerator is below 2^QUOT_W * divisor, so its upper part is already a valid remainder
  always_comb begin
    first.en   = prod_i.en;
    first.rem  = prod_i.num[NUM_W-1:QUOT_W];
    first.bits = prod_i.num[QUOT_W-1:0];
    first.quot = '0;
    first.pix  = prod_i.pix;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    div_t             cur;
    logic [POS_W16:0] trial;

    if (k == 0) begin : g_first
      assign cur = first;
    end else begin : g_next
      assign cur = stg_q[k-1];
    end

    always_comb begin
      stg_d[k] = cur;
      trial    = '0;
      for (int j = 0; j < DivBitsPerStage; j++) begin
        trial         = {stg_d[k].rem, stg_d[k].bits[QUOT_W-1]};
        stg_d[k].bits = stg_d[k].bits << 1;
        if (trial >= {1'b0, divisor_i}) begin
          stg_d[k].rem  = POS_W16'(trial - {1'b0, divisor_i});
          stg_d[k].quot = {stg_d[k].quot[QUOT_W-2:0], 1'b1};
        end else begin
          stg_d[k].rem  = trial[POS_W16-1:0];
          stg_d[k].quot = {stg_d[k].quot[QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DivStages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stg_q <= stg_d;
    end
  end

  assign vld_o = vld_q[DivStages-1];
  assign div_o = stg_q[DivStages-1];

endmodule

@@ src/lso_blend.sv @@
// Blend stages: clamp weight, scale sweep colour, saturating add into the output register.
`timescale 1ns / 1ps
module lso_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  lso_pkg::div_t             div_i,
  input  logic [lso_pkg::COL_W-1:0] color_i,
  output logic                      vld_o,
  output lso_pkg::pix_t             pix_o
);
  import lso_pkg::*;

  logic [WGT_W-1:0] wgt;
  mix_t             mix_d, mix_q;
  pix_t             pix_d, pix_q;
  logic             mix_vld_q, pix_vld_q;

  always_comb begin
    if (!div_i.en) begin
      wgt = '0;
    end else if (div_i.quot > QUOT_W'(WeightOne)) begin
      wgt = WeightOne;
    end else begin
      wgt = div_i.quot[WGT_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      mix_d.ovl[c] = OVL_W'(color_i[c*CH_W +: CH_W]) * OVL_W'(wgt);
    end
    mix_d.pix = div_i.pix;
  end

  // Drop the eight fraction bits of each scaled channel
  always_comb begin
    pix_d.red   = sat_add(mix_q.pix.red,   mix_q.ovl[2][OVL_W-1:CH_W]);
    pix_d.green = sat_add(mix_q.pix.green, mix_q.ovl[1][OVL_W-1:CH_W]);
    pix_d.blue  = sat_add(mix_q.pix.blue,  mix_q.ovl[0][OVL_W-1:CH_W]);
    pix_d.last  = mix_q.pix.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_vld_q <= 1'b0;
      pix_vld_q <= 1'b0;
    end else if (adv_i) begin
      mix_vld_q <= vld_i;
      pix_vld_q <= mix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mix_q <= mix_d;
      pix_q <= pix_d;
    end
  end

  assign vld_o = pix_vld_q;
  assign pix_o = pix_q;

endmodule

@@ src/led_sweep_overlay.sv @@
// Top level: LED sweep overlay with config registers, input skid stage and pixel pipeline.
//
// Usage: pixels arrive on pix_in (index, red, green, blue, last flag), one request
// per clock at most; each produces exactly one pixel on pix_out, in order. A request
// is taken at a rising edge with valid and ready both high on its channel.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0 center,
// 1 width, 2 colour, 3 intensity); the user must write them only while no pixel is in
// flight, since the block itself does not enforce it. Throughput: one pixel per clock,
// sustained while the output is not stalled.
// The pipeline is eight register stages: distance, product, four divider stages of
// three quotient bits each, colour scaling, and the saturating add that feeds the
// output register; the divider sets the depth.
// Reset clears the config registers and every valid bit; the sweep is then disabled.
// When the receiver stalls, the whole pipeline holds; pix_in.ready comes from a
// one-entry skid register, so one more request is still taken and parked there.
`timescale 1ns / 1ps
module led_sweep_overlay #(
  parameter int unsigned MAX_LEDS      = lso_pkg::MaxLeds,
  parameter int unsigned POS_FRAC_BITS = lso_pkg::PosFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lso_pix_in_if.sink                    pix_in,
  lso_pix_out_if.source                 pix_out,
  input  logic                          cfg_we_i,
  input  logic [lso_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lso_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import lso_pkg::*;

  logic [POS_W16-1:0] center_q, width_q;
  logic [COL_W-1:0]   color_q;
  logic [INT_W-1:0]   intens_q;

  logic  adv, in_ready, in_take;
  logic  skid_vld_q;
  req_t  in_req, skid_q, ent_req;
  logic  ent_vld;
  logic  geo_vld, div_vld, out_vld;
  prod_t prod;
  div_t  quot;
  pix_t  out_pix;

  // Configuration writes: decode register index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      width_q  <= '0;
      color_q  <= '0;
      intens_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegCenter:    center_q <= cfg_wdata_i[POS_W16-1:0];
        RegWidth:     width_q  <= cfg_wdata_i[POS_W16-1:0];
        RegColor:     color_q  <= cfg_wdata_i[COL_W-1:0];
        RegIntensity: intens_q <= cfg_wdata_i[INT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished pixel waits on a stalled receiver
  assign adv      = !out_vld || pix_out.ready;
  assign in_ready = !skid_vld_q;
  assign in_take  = pix_in.valid && in_ready;

  assign pix_in.ready = in_ready;

  always_comb begin
    in_req.idx       = pix_in.pixel_index;
    in_req.pix.red   = pix_in.in_red;
    in_req.pix.green = pix_in.in_green;
    in_req.pix.blue  = pix_in.in_blue;
    in_req.pix.last  = pix_in.last_pixel;
  end

  // Feed the first stage from the skid entry first, else straight from the port
  assign ent_vld = skid_vld_q || in_take;
  assign ent_req = skid_vld_q ? skid_q : in_req;

  // Park a request in the skid entry when it arrives during a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      skid_vld_q <= 1'b0;
    end else if (in_take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_take) begin
      skid_q <= in_req;
    end
  end

  lso_geom #(
    .MAX_LEDS      (MAX_LEDS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (ent_vld),
    .req_i    (ent_req),
    .center_i (center_q),
    .width_i  (width_q),
    .intens_i (intens_q),
    .vld_o    (geo_vld),
    .prod_o   (prod)
  );

  lso_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (geo_vld),
    .prod_i    (prod),
    .divisor_i (width_q),
    .vld_o     (div_vld),
    .div_o     (quot)
  );

  lso_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (div_vld),
    .div_i   (quot),
    .color_i (color_q),
    .vld_o   (out_vld),
    .pix_o   (out_pix)
  );

  assign pix_out.valid     = out_vld;
  assign pix_out.out_red   = out_pix.red;
  assign pix_out.out_green = out_pix.green;
  assign pix_out.out_blue  = out_pix.blue;
  assign pix_out.last_out  = out_pix.last;

endmodule
